/* rtl/assembly_source_tokenizer_top_defines.svh */
// Assertion macros used by the tokenizer checker.
`ifndef ASSEMBLY_SOURCE_TOKENIZER_TOP_DEFINES_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define AST_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define AST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ast_pkg.sv */
// Types, constants and helper functions of the assembly source tokenizer.
package ast_pkg;

    localparam int OFFSET_BITS_DEF = 24;
    localparam int LINE_BITS_DEF   = 16;

    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_END  = 1'b1;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'd0,
        MODE_COMMENT = 4'd1,
        MODE_SIGN    = 4'd2,
        MODE_START   = 4'd3,
        MODE_ZERO    = 4'd4,
        MODE_DEC     = 4'd5,
        MODE_HEX     = 4'd6,
        MODE_BIN     = 4'd7,
        MODE_WORD    = 4'd8
    } mode_t;

    typedef enum logic [3:0] {
        KIND_IDENT = 4'd0,
        KIND_REG   = 4'd1,
        KIND_IMM   = 4'd2,
        KIND_LABEL = 4'd3,
        KIND_LBR   = 4'd4,
        KIND_RBR   = 4'd5,
        KIND_PLUS  = 4'd6,
        KIND_MINUS = 4'd7,
        KIND_COMMA = 4'd8,
        KIND_NL    = 4'd9,
        KIND_END   = 4'd10
    } kind_t;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_SEVEN  = 8'h37;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_UP_B   = 8'h42;
    localparam logic [7:0] CH_UP_R   = 8'h52;
    localparam logic [7:0] CH_UP_X   = 8'h58;
    localparam logic [7:0] CH_LBR    = 8'h5B;
    localparam logic [7:0] CH_RBR    = 8'h5D;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_LO_B   = 8'h62;
    localparam logic [7:0] CH_LO_R   = 8'h72;
    localparam logic [7:0] CH_LO_X   = 8'h78;

    // Bits of one packed token: kind, value, line, start, end, last flag.
    function automatic int tok_width(input int line_bits, input int offset_bits);
        return 4 + 32 + line_bits + 2 * offset_bits + 1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // {valid, nibble}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [7:0] d;
        d = 8'h00;
        if (is_digit(c)) begin
            d = c - CH_ZERO;
            return {1'b1, d[3:0]};
        end
        if ((c >= 8'h61) && (c <= 8'h66)) begin
            d = c - 8'h57;
            return {1'b1, d[3:0]};
        end
        if ((c >= 8'h41) && (c <= 8'h46)) begin
            d = c - 8'h37;
            return {1'b1, d[3:0]};
        end
        return 5'b0_0000;
    endfunction

endpackage

/* rtl/ast_lexer.sv */
// Scanner state and the per-byte step that yields up to two tokens.
module ast_lexer #(
    parameter int OFFSET_BITS = ast_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = ast_pkg::LINE_BITS_DEF
) (
    input  logic                                                    clk,
    input  logic                                                    rst_n,
    input  logic                                                    fire,
    input  logic                                                    opcode,
    input  logic [7:0]                                              source_byte,
    output logic [1:0]                                              push_cnt,
    output logic [ast_pkg::tok_width(LINE_BITS, OFFSET_BITS)-1:0]   tok0,
    output logic [ast_pkg::tok_width(LINE_BITS, OFFSET_BITS)-1:0]   tok1
);

    typedef struct packed {
        ast_pkg::kind_t         kind;
        logic [31:0]            value;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] tstart;
        logic [OFFSET_BITS-1:0] tend;
        logic                   last;
    } tok_t;

    ast_pkg::mode_t         mode_reg, mode_next;
    logic                   neg_reg, neg_next;
    logic [31:0]            acc_reg, acc_next;
    logic [OFFSET_BITS-1:0] begin_reg, begin_next;
    logic [1:0]             cnt_reg, cnt_next;
    logic                   cand_reg, cand_next;
    logic [2:0]             digit_reg, digit_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;

    tok_t        t_pend, t_own, imm_tok, word_tok;
    logic        pend_v, own_v;
    logic        as_start, end_imm, do_idle;
    logic [7:0]  c;
    logic [7:0]  dsub;
    logic [31:0] dig;
    logic [4:0]  hv;

    assign c    = source_byte;
    assign dsub = source_byte - ast_pkg::CH_ZERO;
    assign dig  = {28'd0, dsub[3:0]};
    assign hv   = ast_pkg::hex_val(source_byte);

    always_comb
    begin
        imm_tok        = '0;
        imm_tok.kind   = ast_pkg::KIND_IMM;
        imm_tok.value  = neg_reg ? (32'd0 - acc_reg) : acc_reg;
        imm_tok.line   = line_reg;

        word_tok        = '0;
        word_tok.line   = line_reg;
        word_tok.tstart = begin_reg;
        word_tok.tend   = offset_reg;
        if ((cnt_reg == 2'd2) && cand_reg)
        begin
            word_tok.kind  = ast_pkg::KIND_REG;
            word_tok.value = {29'd0, digit_reg};
        end
        else
        begin
            word_tok.kind = ast_pkg::KIND_IDENT;
        end
    end

    always_comb
    begin
        mode_next   = mode_reg;
        neg_next    = neg_reg;
        acc_next    = acc_reg;
        begin_next  = begin_reg;
        cnt_next    = cnt_reg;
        cand_next   = cand_reg;
        digit_next  = digit_reg;
        line_next   = line_reg;
        offset_next = (offset_reg != '1) ? offset_reg + 1'b1 : offset_reg;
        pend_v      = 1'b0;
        own_v       = 1'b0;
        t_pend      = imm_tok;
        t_own       = '0;
        t_own.line  = line_reg;
        as_start    = 1'b0;
        end_imm     = 1'b0;
        do_idle     = 1'b0;

        if (opcode == ast_pkg::OP_END)
        begin
            if (mode_reg == ast_pkg::MODE_WORD)
            begin
                pend_v = 1'b1;
                t_pend = word_tok;
            end
            else if ((mode_reg >= ast_pkg::MODE_SIGN) && (mode_reg <= ast_pkg::MODE_BIN))
            begin
                pend_v = 1'b1;
            end
            own_v       = 1'b1;
            t_own.kind  = ast_pkg::KIND_END;
            mode_next   = ast_pkg::MODE_IDLE;
            neg_next    = 1'b0;
            acc_next    = '0;
            begin_next  = '0;
            cnt_next    = '0;
            cand_next   = 1'b0;
            digit_next  = '0;
            offset_next = '0;
            line_next   = {{(LINE_BITS-1){1'b0}}, 1'b1};
        end
        else
        begin
            case (mode_reg)
                ast_pkg::MODE_COMMENT:
                begin
                    if (c == ast_pkg::CH_NL)
                        do_idle = 1'b1;
                end
                ast_pkg::MODE_SIGN:
                begin
                    mode_next = ast_pkg::MODE_START;
                    if (c == ast_pkg::CH_MINUS)
                        neg_next = 1'b1;
                    else if (c != ast_pkg::CH_PLUS)
                        as_start = 1'b1;
                end
                ast_pkg::MODE_START:
                begin
                    as_start = 1'b1;
                end
                ast_pkg::MODE_ZERO:
                begin
                    if ((c == ast_pkg::CH_LO_X) || (c == ast_pkg::CH_UP_X))
                        mode_next = ast_pkg::MODE_HEX;
                    else if ((c == ast_pkg::CH_LO_B) || (c == ast_pkg::CH_UP_B))
                        mode_next = ast_pkg::MODE_BIN;
                    else if (ast_pkg::is_digit(c))
                    begin
                        acc_next  = dig;
                        mode_next = ast_pkg::MODE_DEC;
                    end
                    else
                        end_imm = 1'b1;
                end
                ast_pkg::MODE_DEC:
                begin
                    if (ast_pkg::is_digit(c))
                        acc_next = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0} + dig;
                    else
                        end_imm = 1'b1;
                end
                ast_pkg::MODE_HEX:
                begin
                    if (hv[4])
                        acc_next = {acc_reg[27:0], hv[3:0]};
                    else
                        end_imm = 1'b1;
                end
                ast_pkg::MODE_BIN:
                begin
                    if ((c == ast_pkg::CH_ZERO) || (c == ast_pkg::CH_ONE))
                        acc_next = {acc_reg[30:0], c[0]};
                    else
                        end_imm = 1'b1;
                end
                ast_pkg::MODE_WORD:
                begin
                    if (ast_pkg::is_alpha(c) || ast_pkg::is_digit(c) ||
                        (c == ast_pkg::CH_USCORE) || (c == ast_pkg::CH_DOT))
                    begin
                        if (cnt_reg == 2'd1)
                        begin
                            if (!((c >= ast_pkg::CH_ZERO) && (c <= ast_pkg::CH_SEVEN)))
                                cand_next = 1'b0;
                            digit_next = c[2:0];
                            cnt_next   = 2'd2;
                        end
                        else
                            cnt_next = 2'd3;
                    end
                    else if (c == ast_pkg::CH_COLON)
                    begin
                        // label: colon is swallowed
                        pend_v      = 1'b1;
                        t_pend      = word_tok;
                        t_pend.kind = ast_pkg::KIND_LABEL;
                        t_pend.value = '0;
                        mode_next   = ast_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        pend_v  = 1'b1;
                        t_pend  = word_tok;
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            if (as_start)
            begin
                if (c == ast_pkg::CH_ZERO)
                    mode_next = ast_pkg::MODE_ZERO;
                else if (ast_pkg::is_digit(c))
                begin
                    acc_next  = dig;
                    mode_next = ast_pkg::MODE_DEC;
                end
                else
                    end_imm = 1'b1;
            end

            if (end_imm)
            begin
                pend_v  = 1'b1;
                t_pend  = imm_tok;
                do_idle = 1'b1;
            end

            if (do_idle)
            begin
                mode_next = ast_pkg::MODE_IDLE;
                case (c)
                    ast_pkg::CH_SPACE, ast_pkg::CH_TAB, ast_pkg::CH_CR:
                    begin
                    end
                    ast_pkg::CH_SEMI:
                        mode_next = ast_pkg::MODE_COMMENT;
                    ast_pkg::CH_NL:
                    begin
                        own_v      = 1'b1;
                        t_own.kind = ast_pkg::KIND_NL;
                        if (line_reg != '1)
                            line_next = line_reg + 1'b1;
                    end
                    ast_pkg::CH_LBR:
                    begin
                        own_v      = 1'b1;
                        t_own.kind = ast_pkg::KIND_LBR;
                    end
                    ast_pkg::CH_RBR:
                    begin
                        own_v      = 1'b1;
                        t_own.kind = ast_pkg::KIND_RBR;
                    end
                    ast_pkg::CH_PLUS:
                    begin
                        own_v      = 1'b1;
                        t_own.kind = ast_pkg::KIND_PLUS;
                    end
                    ast_pkg::CH_MINUS:
                    begin
                        own_v      = 1'b1;
                        t_own.kind = ast_pkg::KIND_MINUS;
                    end
                    ast_pkg::CH_COMMA:
                    begin
                        own_v      = 1'b1;
                        t_own.kind = ast_pkg::KIND_COMMA;
                    end
                    ast_pkg::CH_HASH:
                    begin
                        mode_next = ast_pkg::MODE_SIGN;
                        neg_next  = 1'b0;
                        acc_next  = '0;
                    end
                    default:
                    begin
                        if (ast_pkg::is_alpha(c) || (c == ast_pkg::CH_USCORE) ||
                            (c == ast_pkg::CH_DOT))
                        begin
                            mode_next  = ast_pkg::MODE_WORD;
                            begin_next = offset_reg;
                            cnt_next   = 2'd1;
                            cand_next  = (c == ast_pkg::CH_UP_R) || (c == ast_pkg::CH_LO_R);
                            digit_next = '0;
                        end
                    end
                endcase
            end
        end

        t_own.last  = 1'b1;
        t_pend.last = !own_v;
    end

    assign push_cnt = {1'b0, pend_v} + {1'b0, own_v};
    assign tok0     = pend_v ? t_pend : t_own;
    assign tok1     = t_own;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= ast_pkg::MODE_IDLE;
            neg_reg    <= 1'b0;
            acc_reg    <= '0;
            begin_reg  <= '0;
            cnt_reg    <= '0;
            cand_reg   <= 1'b0;
            digit_reg  <= '0;
            offset_reg <= '0;
            line_reg   <= {{(LINE_BITS-1){1'b0}}, 1'b1};
        end
        else if (fire)
        begin
            mode_reg   <= mode_next;
            neg_reg    <= neg_next;
            acc_reg    <= acc_next;
            begin_reg  <= begin_next;
            cnt_reg    <= cnt_next;
            cand_reg   <= cand_next;
            digit_reg  <= digit_next;
            offset_reg <= offset_next;
            line_reg   <= line_next;
        end
    end

endmodule

/* rtl/assembly_source_tokenizer_top.sv */
// Top level of the assembly source tokenizer: scanner plus result queue.
// Source text enters as one byte word per cycle on the in channel (opcode 0),
// and an end word (opcode 1) flushes a pending token, emits an end token and
// returns the scanner to its reset state. Each byte is handled in the cycle it
// is accepted: the scanner registers update and up to two finished tokens are
// written into a four-entry result queue, which the out channel drains one
// token per cycle while out_ready is high. A token ended by a byte leaves
// before that byte's own token, and last_of_run marks the final token of each
// input word. An accepted byte's tokens are registered in the queue before they
// reach out. in_ready is high while the queue holds two tokens or fewer, so
// bytes flow at one per cycle as long as the consumer keeps pace; sustained
// rate is bound by the single out port when most bytes yield two tokens. Word
// text is reported as byte offsets; offsets and line numbers saturate at their widths.
module assembly_source_tokenizer_top #(
    parameter int OFFSET_BITS = ast_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = ast_pkg::LINE_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  logic [7:0]             source_byte,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [3:0]             token_kind,
    output logic signed [31:0]     token_value,
    output logic [LINE_BITS-1:0]   line_number,
    output logic [OFFSET_BITS-1:0] text_start,
    output logic [OFFSET_BITS-1:0] text_end,
    output logic                   last_of_run
);

    typedef struct packed {
        ast_pkg::kind_t         kind;
        logic [31:0]            value;
        logic [LINE_BITS-1:0]   line;
        logic [OFFSET_BITS-1:0] tstart;
        logic [OFFSET_BITS-1:0] tend;
        logic                   last;
    } tok_t;

    localparam int QDEPTH = 4;

    logic       in_fire, out_fire;
    logic [1:0] push_cnt, push;
    tok_t       tok0, tok1, head;

    tok_t       q_mem [QDEPTH];
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [2:0] count_reg, count_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    ast_lexer #(
        .OFFSET_BITS (OFFSET_BITS),
        .LINE_BITS   (LINE_BITS)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .fire        (in_fire),
        .opcode      (opcode),
        .source_byte (source_byte),
        .push_cnt    (push_cnt),
        .tok0        (tok0),
        .tok1        (tok1)
    );

    assign push = in_fire ? push_cnt : 2'd0;

    // room for a worst-case two-token word
    assign in_ready  = (count_reg <= 3'd2);
    assign out_valid = (count_reg != 3'd0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + push;
        rd_ptr_next = rd_ptr_reg + {1'b0, out_fire};
        count_next  = count_reg + {1'b0, push} - {2'b00, out_fire};
    end

    always_ff @(posedge clk)
    begin
        if (push != 2'd0)
            q_mem[wr_ptr_reg] <= tok0;
        if (push == 2'd2)
            q_mem[wr_ptr_reg + 2'd1] <= tok1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head        = q_mem[rd_ptr_reg];
    assign token_kind  = head.kind;
    assign token_value = $signed(head.value);
    assign line_number = head.line;
    assign text_start  = head.tstart;
    assign text_end    = head.tend;
    assign last_of_run = head.last;

endmodule

/* rtl/ast_checker.sv */
// Port-level checks of the tokenizer and their binding to the top level.
`include "assembly_source_tokenizer_top_defines.svh"

module ast_checker #(
    parameter int OFFSET_BITS = ast_pkg::OFFSET_BITS_DEF,
    parameter int LINE_BITS   = ast_pkg::LINE_BITS_DEF
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   opcode,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [3:0]             token_kind,
    input logic signed [31:0]     token_value,
    input logic [LINE_BITS-1:0]   line_number,
    input logic [OFFSET_BITS-1:0] text_start,
    input logic [OFFSET_BITS-1:0] text_end,
    input logic                   last_of_run
);

    `AST_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_value) && $stable(line_number), "stalled token changed")

    `AST_ASSERT_NOW(a_end_last, out_valid && (token_kind == ast_pkg::KIND_END), last_of_run, "end token not last of run")

    `AST_ASSERT_NOW(a_no_text, out_valid && (token_kind != ast_pkg::KIND_IDENT) && (token_kind != ast_pkg::KIND_REG) && (token_kind != ast_pkg::KIND_LABEL), (text_start == '0) && (text_end == '0), "text offsets on a textless token")

    `AST_ASSERT_NOW(a_no_value, out_valid && (token_kind != ast_pkg::KIND_REG) && (token_kind != ast_pkg::KIND_IMM), token_value == 32'sd0, "value on a valueless token")

    `AST_ASSERT_NEXT(a_end_emits, in_valid && in_ready && (opcode == ast_pkg::OP_END), out_valid, "end word produced no token")

endmodule

bind assembly_source_tokenizer_top ast_checker #(
    .OFFSET_BITS (OFFSET_BITS),
    .LINE_BITS   (LINE_BITS)
) u_ast_checker (.*);
